[rtl/core/zbuffer_triangle_pixel_test_core_assert.svh]
// assertion macros for the depth test core
`ifndef ZBUFFER_TRIANGLE_PIXEL_TEST_CORE_ASSERT_SVH
`define ZBUFFER_TRIANGLE_PIXEL_TEST_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ZB_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ZB_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ZB_ASSERT_IMP(label, clk, rst_n, a, b)
`define ZB_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/core/zbtpt_pkg.sv]
`timescale 1ns / 1ps
package zbtpt_pkg;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned PIX_W   = 9;
  localparam int unsigned Z_W     = 16;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned NUM_W   = 52;
  localparam int unsigned AREA_W  = 26;
  // state codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_NUM   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_WB    = 3'd6;
  localparam logic [2:0] ST_PROD  = 3'd7;
endpackage

[rtl/core/zbtpt_div.sv]
`timescale 1ns / 1ps
module zbtpt_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [zbtpt_pkg::NUM_W-1:0]      dividend,
  input  logic [zbtpt_pkg::AREA_W-1:0]     divisor,
  output logic                             done,
  output logic [zbtpt_pkg::NUM_W-1:0]      quotient
);
  // restoring divider, one quotient bit a cycle, unsigned magnitudes
  localparam int unsigned NW = zbtpt_pkg::NUM_W;
  localparam int unsigned DW = zbtpt_pkg::AREA_W;
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end
  assign done = busy_r && (cnt_r == CW'(1));
  assign quotient = trial >= {1'b0, d_r} ? {q_r[NW-2:0], 1'b1} : {q_r[NW-2:0], 1'b0};
endmodule

[rtl/core/zbuffer_triangle_pixel_test_core.sv]
`timescale 1ns / 1ps
// Depth test core: one pixel against one triangle per request.
// Input: pixel coordinate, three vertices (x, y, depth) and a colour, taken
// at a clock edge with start high and busy low.
// Output: one result per request, held on the out_ ports for exactly one
// cycle while out_valid is high; the receiver cannot stall.
// Steps: edge terms, products, numerator products, then a serial divider
// with a 52-bit quotient for inside pixels, then a depth memory read and
// write back for inside pixels that lie on screen.
// One request is in flight at a time.
// After reset the depth memory is swept to all ones, one entry a cycle over
// all SCREEN_WIDTH*SCREEN_HEIGHT entries (262144 by default), with busy high.
// Off screen pixels report inside_res but never touch the memory.
`include "zbuffer_triangle_pixel_test_core_assert.svh"
module zbuffer_triangle_pixel_test_core #(
  parameter int unsigned SCREEN_WIDTH  = 512,
  parameter int unsigned SCREEN_HEIGHT = 512,
  parameter int unsigned DEPTH_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [zbtpt_pkg::PIX_W-1:0]       in_pixel_x,
  input  logic [zbtpt_pkg::PIX_W-1:0]       in_pixel_y,
  input  logic signed [zbtpt_pkg::COORD_W-1:0] in_v0_x,
  input  logic signed [zbtpt_pkg::COORD_W-1:0] in_v0_y,
  input  logic [zbtpt_pkg::Z_W-1:0]         in_v0_z,
  input  logic signed [zbtpt_pkg::COORD_W-1:0] in_v1_x,
  input  logic signed [zbtpt_pkg::COORD_W-1:0] in_v1_y,
  input  logic [zbtpt_pkg::Z_W-1:0]         in_v1_z,
  input  logic signed [zbtpt_pkg::COORD_W-1:0] in_v2_x,
  input  logic signed [zbtpt_pkg::COORD_W-1:0] in_v2_y,
  input  logic [zbtpt_pkg::Z_W-1:0]         in_v2_z,
  input  logic [zbtpt_pkg::COL_W-1:0]       in_tri_color,
  output logic                              out_valid,
  output logic                              out_inside_res,
  output logic                              out_write_pixel,
  output logic [zbtpt_pkg::PIX_W-1:0]       out_x,
  output logic [zbtpt_pkg::PIX_W-1:0]       out_y,
  output logic [zbtpt_pkg::COL_W-1:0]       out_color,
  output logic [zbtpt_pkg::Z_W-1:0]         out_depth
);
  localparam int unsigned XW = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned NW = zbtpt_pkg::NUM_W;
  localparam int unsigned PW = 28;
  localparam logic [DEPTH_BITS-1:0] DMAX = '1;

  logic [DEPTH_BITS-1:0] mem [DEPTH];
  logic [2:0] st_r, st_nxt;
  logic [AW:0] clr_r;

  logic [zbtpt_pkg::PIX_W-1:0] px_r, py_r;
  logic [zbtpt_pkg::COL_W-1:0] col_r;
  logic [zbtpt_pkg::Z_W-1:0] z0_r;
  logic signed [zbtpt_pkg::Z_W:0] dz1_r, dz2_r;
  logic signed [13:0] ex_r, ey_r, e1x_r, e1y_r, e2x_r, e2y_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic area_neg_r;
  logic [zbtpt_pkg::AREA_W-1:0] aabs_r;
  logic signed [NW-1:0] m1_r, m2_r;
  logic inside_r, onscr_r, neg_r;
  logic [DEPTH_BITS-1:0] depth_r, rd_r;
  logic [AW-1:0] addr_r;

  logic signed [PW-1:0] area_c, n1_c, n2_c, aabs_c, s_c, t_c;
  logic inside_c;
  logic signed [NW-1:0] num_c, numabs_c;
  logic div_start, div_done;
  logic [NW-1:0] quo;
  logic signed [NW+1:0] q_s, dep_c;
  logic [DEPTH_BITS-1:0] sat_c;

  assign busy = (st_r != zbtpt_pkg::ST_IDLE);

  always_comb begin
    area_c = pa_r - pb_r;
    n1_c = pc_r - pd_r;
    n2_c = pe_r - pf_r;
    // s, t relate to n1, n2 sharing the area sign
    s_c = area_c[PW-1] ? -n1_c : n1_c;
    t_c = area_c[PW-1] ? -n2_c : n2_c;
    aabs_c = area_c[PW-1] ? -area_c : area_c;
    inside_c = (aabs_c > 0) && (s_c > 0) && (t_c > 0) && ((s_c + t_c) <= aabs_c);
  end

  always_comb begin
    num_c = m1_r + m2_r;
    numabs_c = num_c[NW-1] ? -num_c : num_c;
    q_s = (neg_r ? -$signed({2'b00, quo}) : $signed({2'b00, quo})) + $signed({{(NW-15){1'b0}}, z0_r});
    dep_c = q_s;
    if (dep_c < 0) sat_c = '0;
    else if (dep_c > $signed({{(NW+2-DEPTH_BITS){1'b0}}, DMAX})) sat_c = DMAX;
    else sat_c = dep_c[DEPTH_BITS-1:0];
  end

  assign div_start = (st_r == zbtpt_pkg::ST_PROD);

  zbtpt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(numabs_c), .divisor(aabs_r),
    .done(div_done), .quotient(quo)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      zbtpt_pkg::ST_CLEAR: if (clr_r == (AW+1)'(DEPTH - 1)) st_nxt = zbtpt_pkg::ST_IDLE;
      zbtpt_pkg::ST_IDLE:  if (start) st_nxt = zbtpt_pkg::ST_MUL;
      zbtpt_pkg::ST_MUL:   st_nxt = zbtpt_pkg::ST_NUM;
      zbtpt_pkg::ST_NUM:   st_nxt = inside_c ? zbtpt_pkg::ST_PROD : zbtpt_pkg::ST_IDLE;
      zbtpt_pkg::ST_PROD:  st_nxt = zbtpt_pkg::ST_DIV;
      zbtpt_pkg::ST_DIV:   if (div_done) st_nxt = onscr_r ? zbtpt_pkg::ST_RD : zbtpt_pkg::ST_IDLE;
      zbtpt_pkg::ST_RD:    st_nxt = zbtpt_pkg::ST_WB;
      zbtpt_pkg::ST_WB:    st_nxt = zbtpt_pkg::ST_IDLE;
      default:             st_nxt = zbtpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= zbtpt_pkg::ST_CLEAR;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == zbtpt_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      out_valid <= ((st_r == zbtpt_pkg::ST_NUM) && !inside_c)
                || ((st_r == zbtpt_pkg::ST_DIV) && div_done && !onscr_r)
                || (st_r == zbtpt_pkg::ST_WB);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
      col_r <= in_tri_color;
      z0_r <= in_v0_z;
      dz1_r <= $signed({1'b0, in_v1_z}) - $signed({1'b0, in_v0_z});
      dz2_r <= $signed({1'b0, in_v2_z}) - $signed({1'b0, in_v0_z});
      ex_r <= $signed({5'b0, in_pixel_x}) - 14'(in_v0_x);
      ey_r <= $signed({5'b0, in_pixel_y}) - 14'(in_v0_y);
      e1x_r <= 14'(in_v1_x) - 14'(in_v0_x);
      e1y_r <= 14'(in_v1_y) - 14'(in_v0_y);
      e2x_r <= 14'(in_v2_x) - 14'(in_v0_x);
      e2y_r <= 14'(in_v2_y) - 14'(in_v0_y);
      onscr_r <= (32'(in_pixel_x) < SCREEN_WIDTH) && (32'(in_pixel_y) < SCREEN_HEIGHT);
    end
    if (st_r == zbtpt_pkg::ST_MUL) begin
      pa_r <= PW'(e1x_r * e2y_r);
      pb_r <= PW'(e2x_r * e1y_r);
      pc_r <= PW'(ex_r * e2y_r);
      pd_r <= PW'(e2x_r * ey_r);
      pe_r <= PW'(e1x_r * ey_r);
      pf_r <= PW'(ex_r * e1y_r);
    end
    if (st_r == zbtpt_pkg::ST_NUM) begin
      area_neg_r <= area_c[PW-1];
      aabs_r <= aabs_c[zbtpt_pkg::AREA_W-1:0];
      inside_r <= inside_c;
    end
    // numerator products, registered from the combinational n1, n2
    m1_r <= NW'(dz1_r * n1_c);
    m2_r <= NW'(dz2_r * n2_c);
    if (st_r == zbtpt_pkg::ST_PROD) neg_r <= num_c[NW-1] ^ area_neg_r;
    if (st_r == zbtpt_pkg::ST_DIV && div_done) begin
      depth_r <= sat_c;
      addr_r <= AW'(px_r) * AW'(SCREEN_HEIGHT) + AW'(py_r);
    end
    if (st_r == zbtpt_pkg::ST_CLEAR) mem[clr_r[AW-1:0]] <= DMAX;
    else if (st_r == zbtpt_pkg::ST_WB && depth_r < rd_r) mem[addr_r] <= depth_r;
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    out_inside_res <= (st_r == zbtpt_pkg::ST_NUM) ? inside_c : inside_r;
    out_write_pixel <= (st_r == zbtpt_pkg::ST_WB) && (depth_r < rd_r);
    out_x <= px_r;
    out_y <= py_r;
    out_color <= col_r;
    out_depth <= (st_r == zbtpt_pkg::ST_NUM) ? '0 :
                 (st_r == zbtpt_pkg::ST_DIV) ? zbtpt_pkg::Z_W'(sat_c) :
                 zbtpt_pkg::Z_W'(depth_r);
  end

  `ZB_ASSERT_IMP(a_wr_inside, clk, rst_n, out_valid && out_write_pixel, out_inside_res)
  `ZB_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ZB_ASSERT_IMP(a_no_out_clear, clk, rst_n, st_r == zbtpt_pkg::ST_CLEAR, !out_valid)
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
  localparam int unsigned COORD_W = zbtpt_pkg::COORD_W;
  localparam int unsigned PIX_W   = zbtpt_pkg::PIX_W;
  localparam int unsigned Z_W     = zbtpt_pkg::Z_W;
  localparam int unsigned COL_W   = zbtpt_pkg::COL_W;

  localparam int unsigned SCR_W = 512;
  localparam int unsigned SCR_H = 512;
  localparam longint DEPTH_FAR = 65535;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [PIX_W-1:0]          px;
    logic [PIX_W-1:0]          py;
    logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2;
    logic [Z_W-1:0]            z0, z1, z2;
    logic [COL_W-1:0]          color;
  } frag_t;

  typedef struct {
    frag_t f;
    bit    drain;
  } frag_job_t;

  typedef struct {
    logic             covered;
    logic             write;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [COL_W-1:0] color;
    logic [Z_W-1:0]   depth;
  } pix_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PIX_W-1:0] in_pixel_x = '0, in_pixel_y = '0;
  logic signed [COORD_W-1:0] in_v0_x = '0, in_v0_y = '0, in_v1_x = '0, in_v1_y = '0;
  logic signed [COORD_W-1:0] in_v2_x = '0, in_v2_y = '0;
  logic [Z_W-1:0] in_v0_z = '0, in_v1_z = '0, in_v2_z = '0;
  logic [COL_W-1:0] in_tri_color = '0;
  logic out_valid, out_inside_res, out_write_pixel;
  logic [PIX_W-1:0] out_x, out_y;
  logic [COL_W-1:0] out_color;
  logic [Z_W-1:0] out_depth;

  frag_job_t  frag_jobs[$];
  pix_write_t pix_writes_due[$];
  logic [Z_W-1:0] nearest_z [0:SCR_W*SCR_H-1];
  logic req_taken = 1'b0;
  int idle_left = 0;
  int errors = 0;
  longint cycles = 0;

  zbuffer_triangle_pixel_test_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .in_v0_x(in_v0_x), .in_v0_y(in_v0_y), .in_v0_z(in_v0_z),
    .in_v1_x(in_v1_x), .in_v1_y(in_v1_y), .in_v1_z(in_v1_z),
    .in_v2_x(in_v2_x), .in_v2_y(in_v2_y), .in_v2_z(in_v2_z),
    .in_tri_color(in_tri_color),
    .out_valid(out_valid), .out_inside_res(out_inside_res),
    .out_write_pixel(out_write_pixel), .out_x(out_x), .out_y(out_y),
    .out_color(out_color), .out_depth(out_depth)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic pix_write_t depth_test(frag_t f);
    longint px, py, x0, y0, x1, y1, x2, y2, z0, z1, z2;
    longint s, t, area, a_abs, n1, n2, num, d;
    int unsigned idx;
    pix_write_t r;
    px = longint'(f.px); py = longint'(f.py);
    x0 = longint'(f.x0); y0 = longint'(f.y0);
    x1 = longint'(f.x1); y1 = longint'(f.y1);
    x2 = longint'(f.x2); y2 = longint'(f.y2);
    z0 = longint'(f.z0); z1 = longint'(f.z1); z2 = longint'(f.z2);
    s = y0 * x2 - x0 * y2 + (y2 - y0) * px + (x0 - x2) * py;
    t = x0 * y1 - y0 * x1 + (y0 - y1) * px + (x1 - x0) * py;
    area = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
    a_abs = area;
    if (area < 0) begin
      s = -s;
      t = -t;
      a_abs = -area;
    end
    r.covered = (a_abs > 0) && (s > 0) && (t > 0) && (s + t <= a_abs);
    r.write = 1'b0;
    d = 0;
    if (r.covered) begin
      n1 = (px - x0) * (y2 - y0) - (x2 - x0) * (py - y0);
      n2 = (x1 - x0) * (py - y0) - (px - x0) * (y1 - y0);
      num = (z1 - z0) * n1 + (z2 - z0) * n2;
      d = z0 + num / area;
      if (d < 0) d = 0;
      if (d > DEPTH_FAR) d = DEPTH_FAR;
      if (px < SCR_W && py < SCR_H) begin
        idx = int'(px) * SCR_H + int'(py);
        if (d[Z_W-1:0] < nearest_z[idx]) begin
          nearest_z[idx] = d[Z_W-1:0];
          r.write = 1'b1;
        end
      end
    end
    r.x = f.px;
    r.y = f.py;
    r.color = f.color;
    r.depth = d[Z_W-1:0];
    return r;
  endfunction

  function automatic frag_t mk_frag(int px, int py, int ax, int ay, int az, int bx, int by,
                                    int bz, int cx, int cy, int cz, int col);
    frag_t f;
    f.px = PIX_W'(px); f.py = PIX_W'(py);
    f.x0 = COORD_W'(ax); f.y0 = COORD_W'(ay); f.z0 = Z_W'(az);
    f.x1 = COORD_W'(bx); f.y1 = COORD_W'(by); f.z1 = Z_W'(bz);
    f.x2 = COORD_W'(cx); f.y2 = COORD_W'(cy); f.z2 = Z_W'(cz);
    f.color = COL_W'(col);
    return f;
  endfunction

  function automatic frag_t rand_frag();
    frag_t f;
    int cx, cy, spread;
    if ($urandom_range(0, 4) == 0) begin
      f.px = PIX_W'($urandom); f.py = PIX_W'($urandom);
      f.x0 = COORD_W'($urandom); f.y0 = COORD_W'($urandom); f.x1 = COORD_W'($urandom);
      f.y1 = COORD_W'($urandom); f.x2 = COORD_W'($urandom); f.y2 = COORD_W'($urandom);
    end else begin
      // hot spot so the same pixels are hit again and again
      if ($urandom_range(0, 1) == 0) begin
        cx = $urandom_range(200, 211); cy = $urandom_range(300, 311);
      end else begin
        cx = $urandom_range(0, 511); cy = $urandom_range(0, 511);
      end
      f.px = PIX_W'(cx); f.py = PIX_W'(cy);
      spread = ($urandom_range(0, 7) == 0) ? 2000 : 24;
      f.x0 = COORD_W'(cx + $urandom_range(0, 2 * spread) - spread);
      f.y0 = COORD_W'(cy + $urandom_range(0, 2 * spread) - spread);
      f.x1 = COORD_W'(cx + $urandom_range(0, 2 * spread) - spread);
      f.y1 = COORD_W'(cy + $urandom_range(0, 2 * spread) - spread);
      f.x2 = COORD_W'(cx + $urandom_range(0, 2 * spread) - spread);
      f.y2 = COORD_W'(cy + $urandom_range(0, 2 * spread) - spread);
    end
    f.z0 = Z_W'($urandom); f.z1 = Z_W'($urandom); f.z2 = Z_W'($urandom);
    f.color = COL_W'($urandom);
    return f;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (frag_jobs.size() > 0 &&
                   !(frag_jobs[0].drain && pix_writes_due.size() > 0)) begin
        if (frag_jobs.size() > 200 && $urandom_range(0, 7) == 0) begin
          idle_left <= $urandom_range(0, 13);
          start <= 1'b0;
        end else begin
          in_pixel_x <= frag_jobs[0].f.px; in_pixel_y <= frag_jobs[0].f.py;
          in_v0_x <= frag_jobs[0].f.x0; in_v0_y <= frag_jobs[0].f.y0;
          in_v0_z <= frag_jobs[0].f.z0;
          in_v1_x <= frag_jobs[0].f.x1; in_v1_y <= frag_jobs[0].f.y1;
          in_v1_z <= frag_jobs[0].f.z1;
          in_v2_x <= frag_jobs[0].f.x2; in_v2_y <= frag_jobs[0].f.y2;
          in_v2_z <= frag_jobs[0].f.z2;
          in_tri_color <= frag_jobs[0].f.color;
          start <= 1'b1;
          void'(frag_jobs.pop_front());
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance, prediction and result check
  always @(posedge clk) begin
    pix_write_t want;
    frag_t f;
    cycles <= cycles + 1;
    req_taken <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (pix_writes_due.size() == 0) begin
        $error("result with nothing outstanding x=%0d y=%0d", out_x, out_y);
        errors = errors + 1;
      end else begin
        want = pix_writes_due.pop_front();
        if (out_inside_res !== want.covered) begin
          $error("inside_res exp %0d got %0d", want.covered, out_inside_res);
          errors = errors + 1;
        end
        if (out_write_pixel !== want.write) begin
          $error("write_pixel exp %0d got %0d", want.write, out_write_pixel);
          errors = errors + 1;
        end
        if (out_x !== want.x) begin
          $error("out_x exp %0d got %0d", want.x, out_x);
          errors = errors + 1;
        end
        if (out_y !== want.y) begin
          $error("out_y exp %0d got %0d", want.y, out_y);
          errors = errors + 1;
        end
        if (out_color !== want.color) begin
          $error("out_color exp %0d got %0d", want.color, out_color);
          errors = errors + 1;
        end
        if (out_depth !== want.depth) begin
          $error("out_depth exp %0d got %0d", want.depth, out_depth);
          errors = errors + 1;
        end
      end
    end
    if (rst_n && start && !busy) begin
      f.px = in_pixel_x; f.py = in_pixel_y;
      f.x0 = in_v0_x; f.y0 = in_v0_y; f.z0 = in_v0_z;
      f.x1 = in_v1_x; f.y1 = in_v1_y; f.z1 = in_v1_z;
      f.x2 = in_v2_x; f.y2 = in_v2_y; f.z2 = in_v2_z;
      f.color = in_tri_color;
      pix_writes_due.push_back(depth_test(f));
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    frag_job_t j;
    for (int i = 0; i < SCR_W * SCR_H; i++) nearest_z[i] = 16'hFFFF;
    j.drain = 1'b0;
    // big triangle at the coordinate extremes, both windings
    j.f = mk_frag(0, 0, -2048, -2048, 0, 2047, -2048, 65535, -2048, 2047, 65535, 15);
    frag_jobs.push_back(j);
    j.f = mk_frag(511, 511, -2048, -2048, 65535, -2048, 2047, 0, 2047, -2048, 0, 0);
    frag_jobs.push_back(j);
    // same again: pixel outside the triangle, no write
    frag_jobs.push_back(j);
    // zero area
    j.f = mk_frag(10, 10, 0, 0, 100, 20, 20, 100, 40, 40, 100, 5);
    frag_jobs.push_back(j);
    j.f = mk_frag(10, 10, 5, 5, 100, 5, 5, 100, 5, 5, 100, 6);
    frag_jobs.push_back(j);
    // near then far then nearer at one pixel
    j.f = mk_frag(50, 50, 40, 40, 1000, 70, 40, 1000, 40, 70, 1000, 3);
    frag_jobs.push_back(j);
    j.f = mk_frag(50, 50, 40, 40, 2000, 70, 40, 2000, 40, 70, 2000, 4);
    frag_jobs.push_back(j);
    j.f = mk_frag(50, 50, 70, 40, 999, 40, 40, 999, 40, 70, 999, 9);
    frag_jobs.push_back(j);
    // pixels on edges, steep planes pushing past the depth range
    j.f = mk_frag(60, 60, 60, 60, 0, 100, 60, 65535, 60, 100, 65535, 1);
    frag_jobs.push_back(j);
    j.f = mk_frag(80, 60, 60, 60, 65535, 100, 60, 0, 60, 100, 0, 2);
    frag_jobs.push_back(j);
    j.f = mk_frag(80, 80, 60, 60, 0, 100, 60, 65535, 60, 100, 0, 7);
    frag_jobs.push_back(j);
    j.f = mk_frag(100, 100, 99, 99, 0, 102, 99, 65535, 99, 102, 65535, 8);
    frag_jobs.push_back(j);
    j.f = mk_frag(300, 300, 2047, 2047, 65535, 2047, -2048, 0, -2048, 2047, 65535, 12);
    frag_jobs.push_back(j);
    j.f = mk_frag(511, 0, 500, -5, 20000, 520, -5, 40000, 511, 10, 30000, 11);
    frag_jobs.push_back(j);
    for (int i = 0; i < 1400; i++) begin
      j.f = rand_frag();
      j.drain = (i % 300 == 150);
      frag_jobs.push_back(j);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (frag_jobs.size() > 0 || start || pix_writes_due.size() > 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
